>>> rtl/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types and constants for the attribute span scanner.
// ----------------------------------------------------------------------------
package asc_pkg;

  // Position width of offsets, indexes and spans
  localparam int unsigned POS_W = 32;

  // Scanner state codes
  localparam logic [2:0] ST_INVALID    = 3'd0;
  localparam logic [2:0] ST_KEY        = 3'd1;
  localparam logic [2:0] ST_PRE_ASSIGN = 3'd2;
  localparam logic [2:0] ST_ASSIGN     = 3'd3;
  localparam logic [2:0] ST_DQ_STRING  = 3'd4;
  localparam logic [2:0] ST_SQ_STRING  = 3'd5;
  localparam logic [2:0] ST_VALUE      = 3'd6;
  localparam logic [2:0] ST_VALID      = 3'd7;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  // Input word
  typedef struct packed {
    logic [7:0]       byte_value;
    logic             first_byte;
    logic             last_byte;
    logic [POS_W-1:0] region_base;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic             span_found;
    logic [POS_W-1:0] span_start;
    logic [POS_W-1:0] span_end;
    logic             region_done;
  } out_word_t;

endpackage

>>> rtl/attribute_span_scanner_top.sv
// ----------------------------------------------------------------------------
// attribute_span_scanner_top
// Scans a tag's attribute region one byte per word and reports attribute spans.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one byte of the attribute region per word,
//   with first_byte opening a region (latches region_base, clears the index
//   and the scanner state) and last_byte closing it.
//   out_valid/out_stall/out_data return exactly one result word per input
//   word: span_found with absolute span_start/span_end, and region_done.
//   A result is registered in the output register, or in the skid register
//   while output is held. Throughput: one byte per cycle when in_stall is low,
//   set by one pass of state update and two position adds ahead of out_r.
//   When the receiver stalls, one more word is taken into a skid register;
//   in_stall then rises until the output drains. Stall never drops data.
//   Reset (rst_n low, synchronous) empties both output registers, sets the
//   scanner to invalid and clears index, key start and base to zero.
//   Positions wrap modulo 2^32.
// ----------------------------------------------------------------------------
module attribute_span_scanner_top
  import asc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  // Scanner state
  logic [2:0]       state_r;
  logic [POS_W-1:0] key_idx_r;
  logic [POS_W-1:0] idx_r;
  logic [POS_W-1:0] base_r;

  // Output and skid stages
  logic      out_valid_r;
  out_word_t out_r;
  logic      skid_valid_r;
  out_word_t skid_r;

  // Next values
  logic [2:0]       state_nxt;
  logic [POS_W-1:0] key_idx_nxt;
  logic [POS_W-1:0] idx_cur;
  logic [POS_W-1:0] base_cur;
  logic [2:0]       s_cur;
  logic [2:0]       s_scan;
  logic             extra;
  logic             is_ws;
  out_word_t        res;

  logic in_acc;
  logic out_take;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Region start overrides stored state
  always_comb begin
    s_cur    = in_data.first_byte ? ST_INVALID : state_r;
    idx_cur  = in_data.first_byte ? '0 : idx_r;
    base_cur = in_data.first_byte ? in_data.region_base : base_r;
    is_ws    = (in_data.byte_value == CH_SPACE) || (in_data.byte_value == CH_TAB) ||
               (in_data.byte_value == CH_LF) || (in_data.byte_value == CH_CR);
  end

  // State transition on the current byte
  always_comb begin
    s_scan      = s_cur;
    extra       = 1'b0;
    key_idx_nxt = key_idx_r;
    if (is_ws) begin
      unique case (s_cur)
        ST_KEY:   s_scan = ST_PRE_ASSIGN;
        ST_VALUE: s_scan = ST_VALID;
        default:  s_scan = s_cur;
      endcase
    end else if (in_data.byte_value == CH_EQ) begin
      unique case (s_cur) inside
        ST_KEY, ST_PRE_ASSIGN: s_scan = ST_ASSIGN;
        ST_ASSIGN, ST_VALUE:   s_scan = ST_INVALID;
        default:               s_scan = s_cur;
      endcase
    end else if (in_data.byte_value == CH_DQ || in_data.byte_value == CH_SQ) begin
      unique case (s_cur) inside
        ST_DQ_STRING: begin
          if (in_data.byte_value == CH_DQ) begin
            s_scan = ST_VALID;
            extra  = 1'b1;
          end
        end
        ST_SQ_STRING: begin
          if (in_data.byte_value == CH_SQ) begin
            s_scan = ST_VALID;
            extra  = 1'b1;
          end
        end
        ST_KEY, ST_PRE_ASSIGN, ST_VALUE: s_scan = ST_INVALID;
        ST_ASSIGN: s_scan = (in_data.byte_value == CH_DQ) ? ST_DQ_STRING : ST_SQ_STRING;
        default:   s_scan = s_cur;
      endcase
    end else begin
      unique case (s_cur)
        ST_INVALID: begin
          s_scan      = ST_KEY;
          key_idx_nxt = idx_cur;
        end
        ST_PRE_ASSIGN: s_scan = ST_INVALID;
        ST_ASSIGN:     s_scan = ST_VALUE;
        default:       s_scan = s_cur;
      endcase
    end
  end

  // Span report and final state
  always_comb begin
    res             = '0;
    res.region_done = in_data.last_byte;
    state_nxt       = s_scan;
    if (s_scan == ST_VALID) begin
      res.span_found = 1'b1;
      res.span_start = base_cur + key_idx_nxt;
      res.span_end   = base_cur + idx_cur + POS_W'(extra);
      state_nxt      = ST_INVALID;
    end else if (in_data.last_byte && s_scan == ST_VALUE) begin
      res.span_found = 1'b1;
      res.span_start = base_cur + key_idx_nxt;
      res.span_end   = base_cur + idx_cur;
    end
    if (in_data.last_byte) begin
      state_nxt = ST_INVALID;
    end
  end

  // Scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INVALID;
      key_idx_r <= '0;
      idx_r     <= '0;
      base_r    <= '0;
    end else if (in_acc) begin
      state_r   <= state_nxt;
      key_idx_r <= key_idx_nxt;
      idx_r     <= idx_cur + POS_W'(1);
      base_r    <= base_cur;
    end
  end

  // Output / skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output / skid payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

`ifndef SYNTH
  // Skid only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word while output register is empty");

  // No span, no positions
  a_empty_span_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.span_found) |-> (out_r.span_start == '0 && out_r.span_end == '0))
    else $error("span positions set without span_found");

  // Region end leaves scanner idle
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_byte) |=> (state_r == ST_INVALID))
    else $error("scanner not idle after last byte");

  // A completed attribute is never left in the stored state
  a_no_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_VALID)
    else $error("valid state stored");

  // Index advances by one per accepted word without region start
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_data.first_byte) |=> (idx_r == $past(idx_r) + POS_W'(1)))
    else $error("byte index did not advance");
`endif

endmodule
